// ===== rtl/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// shared widths, constants, types and helpers of the quaternion to euler core
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int CORDIC_STEPS = 16;   // 8 .. 24
  localparam int TABLE_LEN    = 24;
  localparam int FIELD_W      = 16;
  localparam int PROD_W       = 32;
  localparam int SUM_W        = 34;   // 2(ab+cd) in q30 fits here
  localparam int XY_W         = 37;   // cordic vector with gain headroom
  localparam int Z_W          = 28;   // angle accumulator, 24 fraction bits
  localparam int MAG_W        = 30;
  localparam int SQ_W         = 62;   // root extraction working width
  localparam int SQRT_STAGES  = 31;   // one result bit per stage
  localparam int SH_W         = 5;
  localparam int K_W          = 6;

  localparam logic signed [SUM_W-1:0] ONE_Q30     = SUM_W'(64'sd1073741824);
  localparam logic signed [Z_W-1:0]   PI_Q24      = Z_W'(52707179);
  localparam logic signed [FIELD_W-1:0] HALF_PI_Q13 = FIELD_W'(12868);

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sr;
    logic signed [SUM_W-1:0] cr;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] cy;
    logic signed [SUM_W-1:0] sp;
    logic                    clamp;
  } side_t;

  typedef struct packed {
    logic zero_roll;
    logic zero_yaw;
    logic clamp;
    logic sp_pos;
  } flags_t;

  // atan(2^-i) in q24, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_tab(input logic [SH_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:    v = Z_W'(13176795);
      5'd1:    v = Z_W'(7778716);
      5'd2:    v = Z_W'(4110060);
      5'd3:    v = Z_W'(2086331);
      5'd4:    v = Z_W'(1047214);
      5'd5:    v = Z_W'(524117);
      5'd6:    v = Z_W'(262123);
      5'd7:    v = Z_W'(131069);
      5'd8:    v = Z_W'(65536);
      5'd9:    v = Z_W'(32768);
      5'd10:   v = Z_W'(16384);
      5'd11:   v = Z_W'(8192);
      5'd12:   v = Z_W'(4096);
      5'd13:   v = Z_W'(2048);
      5'd14:   v = Z_W'(1024);
      5'd15:   v = Z_W'(512);
      5'd16:   v = Z_W'(256);
      5'd17:   v = Z_W'(128);
      5'd18:   v = Z_W'(64);
      5'd19:   v = Z_W'(32);
      5'd20:   v = Z_W'(16);
      5'd21:   v = Z_W'(8);
      5'd22:   v = Z_W'(4);
      5'd23:   v = Z_W'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

  // fold the left half plane onto the right one
  function automatic cordic_t cordic_init(input logic signed [SUM_W-1:0] y,
                                          input logic signed [SUM_W-1:0] x);
    cordic_t c;
    if (x < 0) begin
      c.x = -XY_W'(x);
      c.y = -XY_W'(y);
      c.z = (y >= 0) ? PI_Q24 : -PI_Q24;
    end else begin
      c.x = XY_W'(x);
      c.y = XY_W'(y);
      c.z = '0;
    end
    return c;
  endfunction

  // q24 to q13, ties toward +inf, saturated
  function automatic logic signed [FIELD_W-1:0] to_q13(input logic signed [Z_W-1:0] a);
    logic signed [Z_W-1:0] t;
    logic signed [Z_W-12:0] r;
    logic signed [FIELD_W-1:0] q;
    t = a + Z_W'(1024);
    r = t[Z_W-1:11];
    if (r > (Z_W-11)'(32767))
      q = 16'sh7fff;
    else if (r < -(Z_W-11)'(32768))
      q = 16'sh8000;
    else
      q = r[FIELD_W-1:0];
    return q;
  endfunction

endpackage

// ===== rtl/q2e_if.sv =====
// ----------------------------------------------------------------------------
// q2e channel interfaces
// valid/ready channels for quaternion requests and euler results
// ----------------------------------------------------------------------------
interface q2e_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface

interface q2e_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic               pitch_clamped;
  modport source (output valid, output roll_angle, output pitch_angle,
                  output yaw_angle, output pitch_clamped, input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle,
                  input yaw_angle, input pitch_clamped, output ready);
endinterface

// ===== rtl/q2e_sqrt_step.sv =====
// ----------------------------------------------------------------------------
// q2e_sqrt_step
// one digit of the restoring integer square root
// ----------------------------------------------------------------------------
module q2e_sqrt_step
  import q2e_pkg::*;
(
  input  logic [SQ_W-1:0] n_in,
  input  logic [SQ_W-1:0] res_in,
  input  logic [K_W-1:0]  k,
  output logic [SQ_W-1:0] n_out,
  output logic [SQ_W-1:0] res_out
);
  logic [SQ_W-1:0] bit_v;
  logic [SQ_W-1:0] trial;

  assign bit_v = SQ_W'(1) << {k, 1'b0};
  assign trial = res_in + bit_v;

  always_comb begin
    if (n_in >= trial) begin
      n_out   = n_in - trial;
      res_out = (res_in >> 1) + bit_v;
    end else begin
      n_out   = n_in;
      res_out = res_in >> 1;
    end
  end
endmodule

// ===== rtl/q2e_cordic_step.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic_step
// one vectoring micro-rotation, y driven toward zero
// ----------------------------------------------------------------------------
module q2e_cordic_step
  import q2e_pkg::*;
(
  input  cordic_t              cur,
  input  logic [SH_W-1:0]      sh,
  input  logic signed [Z_W-1:0] ang,
  output cordic_t              nxt
);
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  assign dx = cur.y >>> sh;
  assign dy = cur.x >>> sh;

  always_comb begin
    if (cur.y >= 0) begin
      nxt.x = cur.x + dx;
      nxt.y = cur.y - dy;
      nxt.z = cur.z + ang;
    end else begin
      nxt.x = cur.x - dx;
      nxt.y = cur.y + dy;
      nxt.z = cur.z - ang;
    end
  end
endmodule

// ===== rtl/quaternion_to_euler_angles_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// unit quaternion (q1.15) to zyx euler angles roll, pitch, yaw (q3.13 rad)
//
// Fully pipelined: one quaternion request is taken every cycle while the
// output is not stalled. The latency is set by the 31-stage square root
// that feeds the pitch arctangent and by the unrolled cordic stages; roll
// and yaw ride in delay registers alongside the root. The whole pipe
// advances together and holds while a result waits on the output; bubbles
// travel with their valid bits, so nothing is lost or doubled. Pitch is
// clamped to +/-pi/2 with a flag when |2(wy-zx)| reaches one.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core
  import q2e_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  q2e_in_if.sink    in_chan,
  q2e_out_if.source out_chan
);

  localparam int LAST_SQ = SQRT_STAGES - 1;
  localparam int LAST_CD = CORDIC_STEPS - 1;

  // global advance: the pipe moves unless a finished result is held
  logic out_v_r;
  logic en;
  assign en            = !out_v_r || out_chan.ready;
  assign in_chan.ready = en;

  // ---- stage 1: products ----
  logic signed [FIELD_W-1:0] qw, qx, qy, qz;
  assign qw = in_chan.quat_w;
  assign qx = in_chan.quat_x;
  assign qy = in_chan.quat_y;
  assign qz = in_chan.quat_z;

  logic signed [PROD_W-1:0] p_wx_nxt, p_yz_nxt, p_xx_nxt, p_yy_nxt, p_wz_nxt;
  logic signed [PROD_W-1:0] p_xy_nxt, p_zz_nxt, p_wy_nxt, p_zx_nxt;
  logic signed [PROD_W-1:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_wz_r;
  logic signed [PROD_W-1:0] p_xy_r, p_zz_r, p_wy_r, p_zx_r;
  logic                     p_v_r;

  assign p_wx_nxt = qw * qx;
  assign p_yz_nxt = qy * qz;
  assign p_xx_nxt = qx * qx;
  assign p_yy_nxt = qy * qy;
  assign p_wz_nxt = qw * qz;
  assign p_xy_nxt = qx * qy;
  assign p_zz_nxt = qz * qz;
  assign p_wy_nxt = qw * qy;
  assign p_zx_nxt = qz * qx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx_r <= p_wx_nxt;
      p_yz_r <= p_yz_nxt;
      p_xx_r <= p_xx_nxt;
      p_yy_r <= p_yy_nxt;
      p_wz_r <= p_wz_nxt;
      p_xy_r <= p_xy_nxt;
      p_zz_r <= p_zz_nxt;
      p_wy_r <= p_wy_nxt;
      p_zx_r <= p_zx_nxt;
    end
  end

  // ---- stage 2: sine and cosine terms, q30 ----
  side_t s_nxt, s_r;
  logic  s_v_r;

  always_comb begin
    s_nxt.sr    = (SUM_W'(p_wx_r) + SUM_W'(p_yz_r)) <<< 1;
    s_nxt.cr    = ONE_Q30 - ((SUM_W'(p_xx_r) + SUM_W'(p_yy_r)) <<< 1);
    s_nxt.sy    = (SUM_W'(p_wz_r) + SUM_W'(p_xy_r)) <<< 1;
    s_nxt.cy    = ONE_Q30 - ((SUM_W'(p_yy_r) + SUM_W'(p_zz_r)) <<< 1);
    s_nxt.sp    = (SUM_W'(p_wy_r) - SUM_W'(p_zx_r)) <<< 1;
    s_nxt.clamp = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (en) begin
      s_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  // ---- stage 3: clamp test and squared pitch sine ----
  logic signed [SUM_W-1:0] sp_mag;
  logic [MAG_W-1:0]        mag30;
  logic [2*MAG_W-1:0]      sq_nxt, sq_r;
  side_t                   m_nxt, m_r;
  logic                    m_v_r;

  assign sp_mag = (s_r.sp < 0) ? -s_r.sp : s_r.sp;
  assign mag30  = sp_mag[MAG_W-1:0];
  assign sq_nxt = mag30 * mag30;

  always_comb begin
    m_nxt       = s_r;
    m_nxt.clamp = (s_r.sp >= ONE_Q30) || (s_r.sp <= -ONE_Q30);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= s_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
      m_r  <= m_nxt;
    end
  end

  // ---- stage 4: 1 - sin^2 in q60 ----
  logic [SQ_W-1:0] rem_r;
  side_t           rm_r;
  logic            rm_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rm_v_r <= 1'b0;
    end else if (en) begin
      rm_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= (SQ_W'(1) << 60) - SQ_W'(sq_r);
      rm_r  <= m_r;
    end
  end

  // ---- square root pipe, one result bit per stage ----
  logic [SQ_W-1:0] sq_n_r   [SQRT_STAGES];
  logic [SQ_W-1:0] sq_res_r [SQRT_STAGES];
  side_t           sq_side_r[SQRT_STAGES];
  logic            sq_v_r   [SQRT_STAGES];

  genvar gk;
  generate
    for (gk = 0; gk < SQRT_STAGES; gk++) begin : g_sqrt
      logic [SQ_W-1:0] n_in, res_in, n_nxt, res_nxt;
      side_t           side_in;
      logic            v_in;

      if (gk == 0) begin : g_first
        assign n_in    = rem_r;
        assign res_in  = '0;
        assign side_in = rm_r;
        assign v_in    = rm_v_r;
      end else begin : g_rest
        assign n_in    = sq_n_r[gk-1];
        assign res_in  = sq_res_r[gk-1];
        assign side_in = sq_side_r[gk-1];
        assign v_in    = sq_v_r[gk-1];
      end

      q2e_sqrt_step u_step (
        .n_in    (n_in),
        .res_in  (res_in),
        .k       (K_W'(SQRT_STAGES - 1 - gk)),
        .n_out   (n_nxt),
        .res_out (res_nxt)
      );

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sq_v_r[gk] <= 1'b0;
        end else if (en) begin
          sq_v_r[gk] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          sq_n_r[gk]    <= n_nxt;
          sq_res_r[gk]  <= res_nxt;
          sq_side_r[gk] <= side_in;
        end
      end
    end
  endgenerate

  // ---- cordic pre-rotation: fold into the right half plane ----
  side_t                   last_side;
  logic signed [SUM_W-1:0] cp;
  cordic_t                 pre_r[3];
  flags_t                  pre_f_r;
  logic                    pre_v_r;

  assign last_side = sq_side_r[LAST_SQ];
  assign cp        = SUM_W'(sq_res_r[LAST_SQ][MAG_W:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
    end else if (en) begin
      pre_v_r <= sq_v_r[LAST_SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r[0]          <= cordic_init(last_side.sr, last_side.cr);
      pre_r[1]          <= cordic_init(last_side.sp, cp);
      pre_r[2]          <= cordic_init(last_side.sy, last_side.cy);
      pre_f_r.zero_roll <= (last_side.sr == 0) && (last_side.cr == 0);
      pre_f_r.zero_yaw  <= (last_side.sy == 0) && (last_side.cy == 0);
      pre_f_r.clamp     <= last_side.clamp;
      pre_f_r.sp_pos    <= last_side.sp > 0;
    end
  end

  // ---- unrolled cordic: lanes roll, pitch, yaw ----
  cordic_t cd_r  [CORDIC_STEPS][3];
  flags_t  cd_f_r[CORDIC_STEPS];
  logic    cd_v_r[CORDIC_STEPS];

  genvar gi, gl;
  generate
    for (gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
      flags_t f_in;
      logic   v_in;

      if (gi == 0) begin : g_first
        assign f_in = pre_f_r;
        assign v_in = pre_v_r;
      end else begin : g_rest
        assign f_in = cd_f_r[gi-1];
        assign v_in = cd_v_r[gi-1];
      end

      for (gl = 0; gl < 3; gl++) begin : g_lane
        cordic_t c_in, c_nxt;

        if (gi == 0) begin : g_first
          assign c_in = pre_r[gl];
        end else begin : g_rest
          assign c_in = cd_r[gi-1][gl];
        end

        q2e_cordic_step u_step (
          .cur (c_in),
          .sh  (SH_W'(gi)),
          .ang (atan_tab(SH_W'(gi))),
          .nxt (c_nxt)
        );

        always_ff @(posedge clk) begin
          if (en) begin
            cd_r[gi][gl] <= c_nxt;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cd_v_r[gi] <= 1'b0;
        end else if (en) begin
          cd_v_r[gi] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          cd_f_r[gi] <= f_in;
        end
      end
    end
  endgenerate

  // ---- output register: rounding, special cases ----
  logic signed [FIELD_W-1:0] roll_r, pitch_r, yaw_r;
  logic                      clamp_r;
  flags_t                    fl;

  assign fl = cd_f_r[LAST_CD];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= cd_v_r[LAST_CD];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= fl.zero_roll ? '0 : to_q13(cd_r[LAST_CD][0].z);
      yaw_r   <= fl.zero_yaw  ? '0 : to_q13(cd_r[LAST_CD][2].z);
      // clamped pitch takes pi/2 with the sign of its sine
      if (fl.clamp) begin
        pitch_r <= fl.sp_pos ? HALF_PI_Q13 : -HALF_PI_Q13;
      end else begin
        pitch_r <= to_q13(cd_r[LAST_CD][1].z);
      end
      clamp_r <= fl.clamp;
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.roll_angle    = roll_r;
  assign out_chan.pitch_angle   = pitch_r;
  assign out_chan.yaw_angle     = yaw_r;
  assign out_chan.pitch_clamped = clamp_r;

  // ---- assertions ----
  a_clamp_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && clamp_r) |-> (pitch_r == HALF_PI_Q13 || pitch_r == -HALF_PI_Q13))
    else $error("clamped pitch is not +/-pi/2");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && en) |=> p_v_r)
    else $error("accepted request did not enter the pipe");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_chan.ready) |=> (out_v_r && $stable(roll_r) && $stable(pitch_r)
      && $stable(yaw_r) && $stable(clamp_r)))
    else $error("held result changed during stall");

endmodule
